// ===== rtl/core/escr_pkg.sv =====
// shared types and constants for the enhanced second-chance replacement block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package escr_pkg;

	// default build sizes
	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 20;

	// field widths of the words
	localparam int PN_W       = 20;
	localparam int FIDX_OUT_W = 3;
	localparam int FC_W       = 32;
	localparam int CFG_W      = 4;

	// input word: page_number in the low bits, padded to whole bytes
	localparam int S_TDATA_W = 24;

	// output word layout, lowest bit first
	localparam int OFS_HIT  = 0;
	localparam int OFS_FIDX = OFS_HIT + 1;
	localparam int OFS_EVV  = OFS_FIDX + FIDX_OUT_W;
	localparam int OFS_EVP  = OFS_EVV + 1;
	localparam int OFS_EVD  = OFS_EVP + PN_W;
	localparam int OFS_FC   = OFS_EVD + 1;
	localparam int OUT_USED_W = OFS_FC + FC_W;
	localparam int M_TDATA_W  = 64;
	localparam int OUT_PAD_W  = M_TDATA_W - OUT_USED_W;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // take the input word and the tag compare result
		logic commit;   // update the frame table and load the output register
	} cmd_t;

endpackage

// ===== rtl/core/escr_ctrl.sv =====
// controller for the replacement block: sequences accept, update and output
// depends on escr_pkg
`timescale 1ns / 1ps

module escr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output escr_pkg::cmd_t cmd
);
	import escr_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   rdy_q;
	logic   ov_q;
	logic   commit;

	assign commit       = (state_q == ST_EXEC) && (!ov_q || m_tready);
	assign cmd.capture  = s_tvalid && rdy_q;
	assign cmd.commit   = commit;
	assign s_tready     = rdy_q;
	assign m_tvalid     = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
			ov_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && rdy_q) begin
						state_q <= ST_EXEC;
						rdy_q   <= 1'b0;
					end
				end
				ST_EXEC: begin
					// wait here while the previous result still sits unread
					if (commit) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
			if (commit) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/escr_datapath.sv =====
// datapath for the replacement block: frame table, tag compare, clock search
// depends on escr_pkg; driven by escr_ctrl commands
`timescale 1ns / 1ps

module escr_datapath #(
	parameter int FRAMES    = escr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = escr_pkg::PAGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  escr_pkg::cmd_t                 cmd,
	input  logic                           cfg_we,
	input  logic [escr_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [escr_pkg::PN_W-1:0]      in_page,
	input  logic                           in_wr,
	output logic [escr_pkg::M_TDATA_W-1:0] out_word
);
	import escr_pkg::*;

	localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PAD     = 2 ** FIDX_W;
	localparam int CFG_RST = (FRAMES < 8) ? FRAMES : 8;

	// lowest set bit of a frame vector
	function automatic logic [FIDX_W-1:0] lowest(input logic [FRAMES-1:0] v);
		logic [FIDX_W-1:0] idx;
		idx = '0;
		for (int f = FRAMES - 1; f >= 0; f--) begin
			if (v[f]) idx = FIDX_W'(f);
		end
		return idx;
	endfunction

	// first set bit at or after the start, wrapping round
	function automatic logic [FIDX_W-1:0] pick(input logic [FRAMES-1:0] v,
						  input logic [FRAMES-1:0] ge);
		logic [FRAMES-1:0] hi;
		hi = v & ge;
		return (|hi) ? lowest(hi) : lowest(v);
	endfunction

	// frame table
	logic [PAGE_BITS-1:0] page_q [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [FRAMES-1:0]    ref_q;
	logic [FRAMES-1:0]    mod_q;
	logic [FIDX_W-1:0]    ptr_q;
	logic [FC_W-1:0]      faults_q;
	logic [CFG_W-1:0]     cfg_q;

	// captured reference
	logic [PAGE_BITS-1:0] page_s1;
	logic                 wr_s1;
	logic                 hit_s1;
	logic [FIDX_W-1:0]    hidx_s1;

	logic [M_TDATA_W-1:0] out_q;

	logic [CFG_W-1:0]          cfg_eff;
	logic [FRAMES-1:0]         act;
	logic [PAD-1:0]            act_pad;
	logic [PAGE_BITS+PN_W-1:0] in_ext;
	logic [PAGE_BITS-1:0]      page_in;
	logic [FRAMES-1:0]         hv;

	logic [FIDX_W-1:0]   start;
	logic [FRAMES-1:0]   ge;
	logic [FRAMES-1:0]   r_eff, d_eff;
	logic [FRAMES-1:0]   c00, c01, cm0;
	logic [FRAMES-1:0]   clr;
	logic [FIDX_W-1:0]   vic;
	logic [FIDX_W:0]     nxt;
	logic [FIDX_W-1:0]   ptr_nxt;
	logic [FC_W-1:0]     faults_inc;
	logic                vic_valid;
	logic [FRAMES-1:0]   ref_nxt, mod_nxt, valid_nxt;
	logic [FIDX_W-1:0]   res_idx;
	logic [FIDX_W+FIDX_OUT_W-1:0] idx_ext;
	logic [PAGE_BITS+PN_W-1:0]    ev_ext;
	logic                res_evv;
	logic [PN_W-1:0]     res_evp;
	logic                res_evd;
	logic [FC_W-1:0]     res_fc;

	assign in_ext  = {{PAGE_BITS{1'b0}}, in_page};
	assign page_in = in_ext[PAGE_BITS-1:0];
	assign cfg_eff = (cfg_q == '0) ? CFG_W'(1) : cfg_q;

	always_comb begin
		act_pad = '0;
		for (int f = 0; f < FRAMES; f++) begin
			act[f]     = (f < int'(cfg_eff));
			act_pad[f] = act[f];
			hv[f]      = valid_q[f] && act[f] && (page_q[f] == page_in);
		end
	end

	// class search from the pointer
	always_comb begin
		start = act_pad[ptr_q] ? ptr_q : '0;
		r_eff = ref_q & valid_q;
		d_eff = mod_q & valid_q;
		c00   = act & ~r_eff & ~d_eff;
		c01   = act & ~r_eff & d_eff;
		cm0   = act & ~d_eff;
		for (int f = 0; f < FRAMES; f++) begin
			ge[f] = (f >= int'(start));
		end
		clr = '0;
		if (|c00) begin
			vic = pick(c00, ge);
		end else if (|c01) begin
			// second pass strips the reference bits it walks past
			vic = pick(c01, ge);
			for (int f = 0; f < FRAMES; f++) begin
				if (vic >= start)
					clr[f] = act[f] && (f >= int'(start)) && (f < int'(vic));
				else
					clr[f] = act[f] && ((f >= int'(start)) || (f < int'(vic)));
			end
		end else if (|cm0) begin
			// full second pass cleared everything, then a clean frame wins
			vic = pick(cm0, ge);
			clr = act;
		end else begin
			vic = start;
			clr = act;
		end
		nxt        = {1'b0, vic} + (FIDX_W + 1)'(1);
		ptr_nxt    = (!nxt[FIDX_W] && act_pad[nxt[FIDX_W-1:0]]) ? nxt[FIDX_W-1:0] : '0;
		faults_inc = (faults_q == '1) ? faults_q : faults_q + FC_W'(1);
		vic_valid  = valid_q[vic];
	end

	// next table state and result fields
	always_comb begin
		ref_nxt   = ref_q;
		mod_nxt   = mod_q;
		valid_nxt = valid_q;
		ev_ext    = {{PN_W{1'b0}}, page_q[vic]};
		if (hit_s1) begin
			ref_nxt[hidx_s1] = 1'b1;
			mod_nxt[hidx_s1] = mod_q[hidx_s1] | wr_s1;
			res_idx = hidx_s1;
			res_evv = 1'b0;
			res_evp = '0;
			res_evd = 1'b0;
			res_fc  = faults_q;
		end else begin
			ref_nxt        = ref_q & ~clr;
			ref_nxt[vic]   = 1'b1;
			mod_nxt[vic]   = wr_s1;
			valid_nxt[vic] = 1'b1;
			res_idx = vic;
			res_evv = vic_valid;
			res_evp = vic_valid ? ev_ext[PN_W-1:0] : '0;
			res_evd = vic_valid && mod_q[vic];
			res_fc  = faults_inc;
		end
		idx_ext = {{FIDX_OUT_W{1'b0}}, res_idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ref_q    <= '0;
			mod_q    <= '0;
			ptr_q    <= '0;
			faults_q <= '0;
			cfg_q    <= CFG_W'(CFG_RST);
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				valid_q <= valid_nxt;
				ref_q   <= ref_nxt;
				mod_q   <= mod_nxt;
				if (!hit_s1) begin
					ptr_q    <= ptr_nxt;
					faults_q <= faults_inc;
				end
			end
		end
	end

	// page tags and payload registers need no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_s1 <= page_in;
			wr_s1   <= in_wr;
			hit_s1  <= |hv;
			hidx_s1 <= lowest(hv);
		end
		if (cmd.commit) begin
			if (!hit_s1) begin
				page_q[vic] <= page_s1;
			end
			out_q <= {{OUT_PAD_W{1'b0}}, res_fc, res_evd, res_evp, res_evv,
				  idx_ext[FIDX_OUT_W-1:0], hit_s1};
		end
	end

	assign out_word = out_q;

endmodule

// ===== rtl/core/enhanced_second_chance_replacement_top.sv =====
// Enhanced second-chance page replacement over a small frame table. Each
// input word is one page reference (page_number in s_tdata, is_write in
// s_tuser); each one gives exactly one output word with hit, frame, any
// evicted page and its dirty bit, and the saturating fault count. The
// parallel tag compare over all frames runs in the accepting cycle and is
// registered; the execute state then does the clock class search from the
// pointer and updates the table and the output register; no new word is
// accepted before that update. If the previous result has not been taken,
// the execute state waits until the output register is free. The user must
// write the frame count register (frames_in_use) on the cfg channel only
// while no reference is in flight; the block does not enforce this. 0 acts
// as 1, values above FRAMES act as FRAMES. No clearing pass follows reset.
// depends on escr_pkg, escr_ctrl, escr_datapath
`timescale 1ns / 1ps

module enhanced_second_chance_replacement_top #(
	parameter int FRAMES    = escr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = escr_pkg::PAGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [escr_pkg::S_TDATA_W-1:0] s_tdata,   // page_number
	input  logic                           s_tuser,   // is_write
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// hit, frame_index, evicted_valid, evicted_page, evicted_dirty, fault_count
	output logic [escr_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [escr_pkg::CFG_W-1:0]     cfg_data   // frames_in_use
);
	import escr_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	escr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	escr_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid),
		.cfg_wdata (cfg_data),
		.in_page   (s_tdata[PN_W-1:0]),
		.in_wr     (s_tuser),
		.out_word  (m_tdata)
	);

endmodule

// ===== rtl/core/escr_checker.sv =====
// port-level checks for the replacement block, bound to the top level
// depends on escr_pkg
`timescale 1ns / 1ps

module escr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [escr_pkg::M_TDATA_W-1:0] m_tdata
);
	import escr_pkg::*;

	// one reference in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted in two consecutive cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OFS_HIT] |-> !m_tdata[OFS_EVV])
		else $error("hit reported an eviction");

	// without an eviction the evicted fields read zero
	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[OFS_EVV] |->
			(m_tdata[OFS_EVP +: PN_W] == '0) && !m_tdata[OFS_EVD])
		else $error("evicted fields set without an eviction");

	// a fault always leaves a nonzero fault count
	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[OFS_HIT] |-> (m_tdata[OFS_FC +: FC_W] != '0))
		else $error("fault reported with zero fault count");

endmodule

bind enhanced_second_chance_replacement_top escr_checker u_escr_checker (.*);

// ===== tb/sv/enhanced_second_chance_replacement_top_tb.sv =====
// testbench for the enhanced second-chance page replacement block: directed
// and random page references checked against a scoreboard with its own frame table
// depends on escr_pkg and enhanced_second_chance_replacement_top
`timescale 1ns / 1ps

module enhanced_second_chance_replacement_top_tb;
	import escr_pkg::*;

	localparam int TABLE_FRAMES = FRAMES_DEF;

	typedef struct {
		bit              hit;
		bit [2:0]        frame;
		bit              ev_valid;
		bit [PN_W-1:0]   ev_page;
		bit              ev_dirty;
		bit [FC_W-1:0]   faults;
	} outcome_t;

	class replacement_board;
		bit [PN_W-1:0] page_of [TABLE_FRAMES];
		bit            resident [TABLE_FRAMES];
		bit            ref_b [TABLE_FRAMES];
		bit            mod_b [TABLE_FRAMES];
		int            hand;
		bit [FC_W-1:0] faults;
		bit [CFG_W-1:0] frames_reg;
		outcome_t      due [$];
		int            errors, checked, hits, evictions, dirty_evictions;

		function new();
			for (int f = 0; f < TABLE_FRAMES; f++) begin
				resident[f] = 0;
				ref_b[f] = 0;
				mod_b[f] = 0;
			end
			hand = 0;
			faults = '0;
			frames_reg = CFG_W'((TABLE_FRAMES < 8) ? TABLE_FRAMES : 8);
		endfunction

		function void set_frames(bit [CFG_W-1:0] v);
			frames_reg = v;
		endfunction

		function int active();
			if (frames_reg < 1)
				return 1;
			if (frames_reg > TABLE_FRAMES)
				return TABLE_FRAMES;
			return int'(frames_reg);
		endfunction

		// one sweep of the hand for class (ref 0, mod want_mod); empty frames are (0,0)
		function int sweep(int m, int start, bit want_mod, bit clear);
			int f;
			for (int n = 0; n < m; n++) begin
				f = (start + n) % m;
				if (!(resident[f] && ref_b[f]) && ((resident[f] && mod_b[f]) == want_mod))
					return f;
				if (clear)
					ref_b[f] = 0;
			end
			return -1;
		endfunction

		function void note_ref(bit [PN_W-1:0] pg, bit wr);
			outcome_t o;
			int m;
			int start;
			int pick;
			o.hit = 0;
			o.ev_valid = 0;
			o.ev_page = '0;
			o.ev_dirty = 0;
			m = active();
			pick = -1;
			// lowest matching frame wins when a page sits in two frames
			for (int f = 0; f < m && pick < 0; f++)
				if (resident[f] && page_of[f] == pg)
					pick = f;
			if (pick >= 0) begin
				o.hit = 1;
				ref_b[pick] = 1;
				mod_b[pick] = mod_b[pick] | wr;
				hits++;
			end else begin
				start = (hand < m) ? hand : 0;
				if (faults != '1)
					faults++;
				for (int round = 0; round < 2 && pick < 0; round++) begin
					pick = sweep(m, start, 1'b0, 1'b0);
					if (pick < 0)
						pick = sweep(m, start, 1'b1, 1'b1);
				end
				if (resident[pick]) begin
					o.ev_valid = 1;
					o.ev_page = page_of[pick];
					o.ev_dirty = mod_b[pick];
					evictions++;
					if (mod_b[pick])
						dirty_evictions++;
				end
				page_of[pick] = pg;
				resident[pick] = 1;
				ref_b[pick] = 1;
				mod_b[pick] = wr;
				hand = (pick + 1) % m;
			end
			o.frame = 3'(pick);
			o.faults = faults;
			due.push_back(o);
		endfunction

		function void check_result(bit [M_TDATA_W-1:0] w);
			outcome_t o;
			if (due.size() == 0) begin
				$error("result word with no reference waiting: %h", w);
				errors++;
				return;
			end
			o = due.pop_front();
			checked++;
			if (w[OFS_HIT] != o.hit) begin
				$error("hit: expected %0d, got %0d", o.hit, w[OFS_HIT]);
				errors++;
			end
			if (w[OFS_FIDX +: FIDX_OUT_W] != o.frame) begin
				$error("frame_index: expected %0d, got %0d", o.frame, w[OFS_FIDX +: FIDX_OUT_W]);
				errors++;
			end
			if (w[OFS_EVV] != o.ev_valid) begin
				$error("evicted_valid: expected %0d, got %0d", o.ev_valid, w[OFS_EVV]);
				errors++;
			end
			if (w[OFS_EVP +: PN_W] != o.ev_page) begin
				$error("evicted_page: expected %h, got %h", o.ev_page, w[OFS_EVP +: PN_W]);
				errors++;
			end
			if (w[OFS_EVD] != o.ev_dirty) begin
				$error("evicted_dirty: expected %0d, got %0d", o.ev_dirty, w[OFS_EVD]);
				errors++;
			end
			if (w[OFS_FC +: FC_W] != o.faults) begin
				$error("fault_count: expected %0d, got %0d", o.faults, w[OFS_FC +: FC_W]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // page_number
	logic                 s_tuser;   // is_write
	logic                 m_tvalid;
	logic                 m_tready;
	// hit, frame_index, evicted_valid, evicted_page, evicted_dirty, fault_count
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;   // frames_in_use

	replacement_board board = new();
	bit calm = 0;
	int settings = 0;
	bit [PN_W-1:0] pool [16];

	enhanced_second_chance_replacement_top #(
		.FRAMES(FRAMES_DEF),
		.PAGE_BITS(PAGE_BITS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// all three channels are observed here, before the edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (s_tvalid && s_tready)
				board.note_ref(s_tdata[PN_W-1:0], s_tuser);
			if (cfg_valid && cfg_ready)
				board.set_frames(cfg_data);
		end
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 11);
	end

	// valid stays high from one word to the next unless a gap is drawn
	task automatic send_ref(input bit [PN_W-1:0] pg, input bit wr);
		while (!calm && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - PN_W){1'b0}}, pg};
		s_tuser <= wr;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (board.due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_frames(input bit [CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
		@(negedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		bit [CFG_W-1:0] plan [10];
		int span;
		plan = '{4'd1, 4'd15, 4'd4, 4'd0, 4'd6, 4'd8, 4'd2, 4'd11, 4'd3, 4'd7};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset frame count: fill the table, then force a full clock sweep
		send_ref(20'h00000, 1'b1);
		send_ref(20'hFFFFF, 1'b0);
		send_ref(20'h00000, 1'b0);
		send_ref(20'hFFFFF, 1'b1);
		send_ref(20'h55555, 1'b0);
		send_ref(20'hAAAAA, 1'b1);
		send_ref(20'h00003, 1'b0);
		send_ref(20'h00004, 1'b1);
		send_ref(20'h00005, 1'b0);
		send_ref(20'h00006, 1'b0);
		send_ref(20'h00007, 1'b1);
		send_ref(20'h00000, 1'b0);
		// shrink: hand likely beyond the active frames, hidden pages fault back in
		write_frames(4'd2);
		send_ref(20'h00005, 1'b1);
		send_ref(20'h00006, 1'b0);
		send_ref(20'h55555, 1'b1);
		// grow past the table size: hidden copies return, lowest frame hits
		write_frames(4'd15);
		send_ref(20'h00005, 1'b0);
		send_ref(20'h00006, 1'b1);
		send_ref(20'h55555, 1'b0);
		// zero behaves as a single frame
		write_frames(4'd0);
		send_ref(20'h00009, 1'b0);
		send_ref(20'h00009, 1'b1);
		send_ref(20'h0000A, 1'b0);
		write_frames(4'd9);
		send_ref(20'hAAAAA, 1'b0);
		send_ref(20'h00011, 1'b1);

		foreach (pool[i])
			pool[i] = PN_W'($urandom_range(20'hFFFFF, 0));
		for (int phase = 0; phase < 10; phase++) begin
			write_frames(plan[phase]);
			calm = (phase == 4 || phase == 5);
			// refresh part of the working set so old pages age out
			for (int i = 0; i < 4; i++)
				pool[4'($urandom_range(15, 0))] = PN_W'($urandom_range(20'hFFFFF, 0));
			span = $urandom_range(15, 2);
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(99) < 78)
					send_ref(pool[4'($urandom_range(span, 0))], 1'($urandom_range(1, 0)));
				else
					send_ref(PN_W'($urandom_range(20'hFFFFF, 0)), 1'($urandom_range(1, 0)));
			end
		end
		calm = 0;
		settle();

		if (board.due.size() != 0) begin
			$error("%0d results never arrived", board.due.size());
			board.errors++;
		end
		$display("%0d references checked over %0d frame count settings", board.checked,
			settings);
		$display("%0d hits, %0d evictions of which %0d dirty, %0d faults", board.hits,
			board.evictions, board.dirty_evictions, board.faults);
		if (board.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
